@@ sv/pat_pkg.sv @@
// package with word types, codes and state encoding for the periodic alarm table
`timescale 1ns / 1ps
package pat_pkg;

  localparam logic [1:0] REQ_REG   = 2'd0;
  localparam logic [1:0] REQ_UNREG = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_UNREG = 2'd1;
  localparam logic [1:0] KIND_FIRE  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam int ADDR_W = 8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] alarm_period;
    logic [3:0]  alarm_id;
  } req_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [3:0] result_id;
    logic       ok;
    logic       last;
  } rsp_word_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       period;
    logic [31:0]       residue;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

@@ sv/pat_residue_unit.sv @@
// period and residue store with the shared residue increment and wrap compare
`timescale 1ns / 1ps
module pat_residue_unit
  import pat_pkg::*;
#(
  parameter int ALARM_SLOTS = 16
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rd_period,
  output logic [31:0] rd_residue,
  output logic [31:0] residue_next,
  output logic        residue_zero
);

  localparam int SW = $clog2(ALARM_SLOTS);

  logic [31:0] period_mem  [ALARM_SLOTS];
  logic [31:0] residue_mem [ALARM_SLOTS];
  logic [SW-1:0] a;
  logic [31:0]   r1;

  assign a = req.addr[SW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      period_mem[a]  <= req.period;
      residue_mem[a] <= req.residue;
    end
    rd_period  <= period_mem[a];
    rd_residue <= residue_mem[a];
  end

  assign r1           = rd_residue + 32'd1;
  assign residue_next = (r1 == rd_period) ? 32'd0 : r1;
  assign residue_zero = (rd_residue == 32'd0);

endmodule

@@ sv/periodic_alarm_table_unit.sv @@
// periodic alarm table top level: request sequencer, slot flags and result register
`timescale 1ns / 1ps
// Every slot keeps its period and its tick count modulo the period, so a tick needs
// only an increment and compare per slot. One request is handled at a time. A
// register request searches from the rolling pointer for a free slot, one slot a
// cycle; an unregister is answered straight from idle; a tick does a memory read
// and a check for each slot through the one residue unit, then the tick-done word.
// A stalled result word holds the sequencer.
module periodic_alarm_table_unit
  import pat_pkg::*;
#(
  parameter int ALARM_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int SW = $clog2(ALARM_SLOTS);
  localparam int LW = $clog2(ALARM_SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(ALARM_SLOTS - 1);
  localparam logic [LW-1:0] FULL_CNT  = LW'(ALARM_SLOTS - 1);

  state_t                 state;
  logic [SW-1:0]          slot;
  logic [SW-1:0]          ptr;
  logic [LW-1:0]          live;
  logic [ALARM_SLOTS-1:0] used;
  logic [ALARM_SLOTS-1:0] on;
  logic [ALARM_SLOTS-1:0] pend;
  logic [ALARM_SLOTS-1:0] fresh;
  logic [31:0]            period_q;

  mem_req_t    mreq;
  logic [31:0] rd_period;
  logic [31:0] rd_residue;
  logic [31:0] residue_next;
  logic        residue_zero;

  logic          out_free;
  logic          acc;
  logic          fire;
  logic          id_ok;
  logic          reg_refuse;
  logic          rsp_load;
  logic [SW-1:0] idx;
  logic [SW-1:0] slot_inc;

  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = !((state == S_IDLE) && out_free);
  assign acc        = req_valid && !req_stall;
  assign idx        = SW'(req.alarm_id);
  assign id_ok      = (32'(req.alarm_id) < 32'(ALARM_SLOTS)) && used[idx];
  assign slot_inc   = (slot == LAST_SLOT) ? '0 : slot + SW'(1);
  assign fire       = used[slot] && on[slot] && !fresh[slot] && residue_zero;
  assign reg_refuse = (req.alarm_period == 32'd0) || (live >= FULL_CNT);
  assign rsp_load   = (acc && ((req.req_type == REQ_UNREG) ||
                               ((req.req_type == REQ_REG) && reg_refuse)))
                   || ((state == S_SRCH) && !used[slot] && out_free)
                   || ((state == S_CHK) && fire && out_free)
                   || ((state == S_DONE) && out_free);

  always_comb begin
    mreq.addr    = ADDR_W'(slot);
    mreq.wr_en   = 1'b0;
    mreq.period  = rd_period;
    mreq.residue = residue_next;
    if (state == S_SRCH) begin
      mreq.period  = period_q;
      mreq.residue = 32'd0;
      mreq.wr_en   = !used[slot] && out_free;
    end else if (state == S_CHK) begin
      mreq.wr_en = used[slot] && (!fire || out_free);
    end
  end

  pat_residue_unit #(
    .ALARM_SLOTS(ALARM_SLOTS)
  ) u_residue (
    .clk         (clk),
    .req         (mreq),
    .rd_period   (rd_period),
    .rd_residue  (rd_residue),
    .residue_next(residue_next),
    .residue_zero(residue_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      ptr       <= '0;
      live      <= '0;
      used      <= '0;
      on        <= '0;
      pend      <= '0;
      fresh     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (req.req_type)
              REQ_REG: begin
                if (reg_refuse) begin
                  rsp <= '{KIND_REG, 4'd0, 1'b0, 1'b1};
                end else begin
                  period_q <= req.alarm_period;
                  slot     <= ptr;
                  state    <= S_SRCH;
                end
              end
              REQ_UNREG: begin
                if (id_ok) begin
                  on[idx]   <= 1'b0;
                  pend[idx] <= 1'b1;
                  rsp       <= '{KIND_UNREG, req.alarm_id, 1'b1, 1'b1};
                end else begin
                  rsp <= '{KIND_UNREG, 4'd0, 1'b0, 1'b1};
                end
              end
              REQ_TICK: begin
                slot  <= '0;
                state <= S_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_SRCH: begin
          if (used[slot]) begin
            slot <= slot_inc;
          end else if (out_free) begin
            used[slot]  <= 1'b1;
            on[slot]    <= 1'b1;
            pend[slot]  <= 1'b0;
            fresh[slot] <= 1'b1;
            live        <= live + LW'(1);
            ptr         <= slot_inc;
            rsp         <= '{KIND_REG, 4'(slot), 1'b1, 1'b1};
            state       <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (!fire || out_free) begin
            if (fire) begin
              rsp <= '{KIND_FIRE, 4'(slot), 1'b1, 1'b0};
            end
            fresh[slot] <= 1'b0;
            if (pend[slot]) begin
              pend[slot] <= 1'b0;
              on[slot]   <= 1'b0;
              used[slot] <= 1'b0;
              live       <= live - LW'(1);
            end
            if (slot == LAST_SLOT) begin
              state <= S_DONE;
            end else begin
              slot  <= slot + SW'(1);
              state <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp   <= '{KIND_DONE, 4'd0, 1'b1, 1'b1};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_live_bound: assert property (@(posedge clk) disable iff (rst) live <= FULL_CNT)
    else $error("live count above table limit");
  a_pend_used: assert property (@(posedge clk) disable iff (rst) (pend & ~used) == '0)
    else $error("pending free on unused slot");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> req_stall)
    else $error("request taken while busy");
  a_on_used: assert property (@(posedge clk) disable iff (rst) (on & ~used) == '0)
    else $error("slot on but not used");
`endif

endmodule
